// ===== src/mphl_pkg.sv =====
// ----------------------------------------------------------------------------
// mphl_pkg
// shared types, opcodes, hash constants and popcount for the mph lookup
// ----------------------------------------------------------------------------
package mphl_pkg;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_KEY    = 2'd1;
	localparam logic [1:0] OP_RANK   = 2'd2;
	localparam logic [1:0] OP_SIZE   = 2'd3;

	localparam logic [31:0] MM_C1  = 32'hCC9E2D51;
	localparam logic [31:0] MM_C2  = 32'h1B873593;
	localparam logic [31:0] MM_ADD = 32'hE6546B64;
	localparam logic [31:0] MM_F1  = 32'h85EBCA6B;
	localparam logic [31:0] MM_F2  = 32'hC2B2AE35;
	localparam logic [31:0] MM_LEN = 32'd8;

	typedef struct packed {
		logic [1:0]  op;
		logic [20:0] scalar;
		logic [2:0]  level;
		logic [9:0]  address;
		logic [63:0] data;
	} cmd_t;

	typedef struct packed {
		logic [15:0] result_index;
		logic        found;
	} res_t;

	function automatic logic [6:0] pop64(input logic [63:0] x);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			n = n + 7'(x[i]);
		end
		return n;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage

// ===== src/minimal_perfect_hash_lookup_top.sv =====
// ----------------------------------------------------------------------------
// minimal_perfect_hash_lookup_top
// multi-level minimal perfect hash lookup over on-chip key and rank memories
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Write words (key word,
// rank entry, level size) land at that edge and raise no busy, so a new word
// may follow in the next cycle. A lookup word raises busy; each searched level
// of nonzero size picks up the size, runs the hash (one shared 32x32
// multiplier, one step a cycle), the modulo (a restoring divider, one quotient
// bit a cycle) and the key word (read, then test); a level of size zero is
// passed over once its size is seen. At the hit level the rank is read, then
// each earlier key word in the 512-bit block (up to 7, one read port on the key
// memory) is counted in turn, then the index is formed; a miss closes the
// search in a state of its own. The result shows for exactly one cycle with
// done high, the first cycle with busy low, and cannot be held off. Key and
// rank entries hold nothing after reset and must be written before a lookup
// reads them; level sizes reset to zero and a zero-size level is skipped.
// level_count is written only while idle.
module minimal_perfect_hash_lookup_top #(
	parameter int MAX_LEVELS          = 8,
	parameter int KEY_WORDS_PER_LEVEL = 1024,
	parameter int RANKS_PER_LEVEL     = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mphl_pkg::cmd_t cmd,
	output logic          done,
	output mphl_pkg::res_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data
);
	import mphl_pkg::*;

	localparam int KA_W = $clog2(MAX_LEVELS * KEY_WORDS_PER_LEVEL);
	localparam int RA_W = (MAX_LEVELS * RANKS_PER_LEVEL > 1) ?
		$clog2(MAX_LEVELS * RANKS_PER_LEVEL) : 1;
	localparam int LV_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LC_W = $clog2(MAX_LEVELS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LVL  = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_KRD  = 4'd4;
	localparam logic [3:0] S_KCHK = 4'd5;
	localparam logic [3:0] S_RANK = 4'd6;
	localparam logic [3:0] S_POP  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_MISS = 4'd9;

	// storage: key words and rank entries in synchronous memories
	logic [63:0] key_mem [MAX_LEVELS*KEY_WORDS_PER_LEVEL];
	logic [15:0] rank_mem [MAX_LEVELS*RANKS_PER_LEVEL];
	logic [15:0] size_q [MAX_LEVELS];
	logic [3:0]  level_count_q;

	logic [3:0]  state_q;
	logic [LC_W-1:0] lv_q;
	logic [20:0] scalar_q;
	logic [15:0] lsize_q;
	logic [3:0]  hstep_q;
	logic [31:0] t_q, h_q;
	logic [4:0]  dcnt_q;
	logic [15:0] rem_q;
	logic [63:0] word_q;
	logic [2:0]  jc_q;
	logic [15:0] acc_q;
	logic        rk_ok_q;

	logic [63:0] key_rd;
	logic [15:0] rank_rd;
	logic [KA_W-1:0] key_raddr, key_waddr;
	logic [RA_W-1:0] rank_raddr, rank_waddr;
	logic        key_we, rank_we, take;
	logic [LC_W:0] n_lv;
	logic [31:0] m_a, m_b, m_c, prod;
	logic [16:0] shifted, trial;
	logic [9:0]  wi;
	logic [5:0]  bitpos;
	logic [6:0]  rk;
	logic        wi_ok;
	logic [31:0] kbase, rbase, kw_tmp, rk_tmp;
	logic [63:0] below_mask;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign take      = start && !busy;

	// write path straight from the command word
	assign kw_tmp     = 32'(cmd.level) * 32'(KEY_WORDS_PER_LEVEL) + 32'(cmd.address);
	assign rk_tmp     = 32'(cmd.level) * 32'(RANKS_PER_LEVEL) + 32'(cmd.address);
	assign key_waddr  = kw_tmp[KA_W-1:0];
	assign rank_waddr = rk_tmp[RA_W-1:0];
	assign key_we  = take && (cmd.op == OP_KEY) && (32'(cmd.level) < 32'(MAX_LEVELS))
		&& (32'(cmd.address) < 32'(KEY_WORDS_PER_LEVEL));
	assign rank_we = take && (cmd.op == OP_RANK) && (32'(cmd.level) < 32'(MAX_LEVELS))
		&& (32'(cmd.address) < 32'(RANKS_PER_LEVEL));

	// index fields of the reduced hash
	assign wi     = rem_q[15:6];
	assign bitpos = rem_q[5:0];
	assign rk     = rem_q[15:9];
	assign wi_ok  = (32'(wi) < 32'(KEY_WORDS_PER_LEVEL));
	assign kbase  = 32'(lv_q) * 32'(KEY_WORDS_PER_LEVEL);
	assign rbase  = 32'(lv_q) * 32'(RANKS_PER_LEVEL) + 32'(rk);
	assign rank_raddr = rbase[RA_W-1:0];
	assign below_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << bitpos);

	always_comb begin
		logic [31:0] ka;
		case (state_q)
			S_RANK:  ka = kbase + 32'({wi[9:3], 3'b000});
			S_POP:   ka = kbase + 32'({wi[9:3], jc_q + 3'd1});
			default: ka = kbase + 32'(wi);
		endcase
		key_raddr = ka[KA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= cmd.data;
		end
		key_rd <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= cmd.data[15:0];
		end
		rank_rd <= rank_mem[rank_raddr];
	end

	// levels beyond the table count as not there
	assign n_lv = (5'(level_count_q) > 5'(MAX_LEVELS)) ? (LC_W+1)'(MAX_LEVELS)
		: (LC_W+1)'(level_count_q);

	// one shared multiplier, operands picked by hash step
	always_comb begin
		logic [31:0] x;
		x   = '0;
		m_a = '0;
		m_b = 32'd1;
		m_c = '0;
		case (hstep_q)
			4'd0: begin m_a = 32'(scalar_q); m_b = MM_C1; end
			4'd1: begin m_a = rotl(t_q, 15); m_b = MM_C2; end
			4'd2: begin m_a = rotl(32'(lv_q) ^ t_q, 13); m_b = 32'd5; m_c = MM_ADD; end
			4'd3: begin m_a = 32'(lsize_q); m_b = MM_C1; end
			4'd4: begin m_a = rotl(t_q, 15); m_b = MM_C2; end
			4'd5: begin m_a = rotl(h_q ^ t_q, 13); m_b = 32'd5; m_c = MM_ADD; end
			4'd6: begin
				x   = h_q ^ MM_LEN;
				m_a = x ^ (x >> 16);
				m_b = MM_F1;
			end
			4'd7: begin m_a = h_q ^ (h_q >> 13); m_b = MM_F2; end
			default: begin m_a = h_q ^ (h_q >> 16); end
		endcase
	end
	assign prod = m_a * m_b + m_c;

	// restoring remainder, one dividend bit a step
	assign shifted = {rem_q, h_q[31]};
	assign trial   = shifted - {1'b0, lsize_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_count_q <= '0;
			done          <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				size_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				level_count_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (cmd.op == OP_LOOKUP) begin
							state_q <= S_LVL;
						end else if (cmd.op == OP_SIZE) begin
							for (int i = 0; i < MAX_LEVELS; i++) begin
								if (32'(cmd.level) == i) begin
									size_q[i] <= cmd.data[15:0];
								end
							end
						end
					end
				end
				S_LVL: begin
					if ({1'b0, lv_q} >= n_lv) begin
						state_q <= S_MISS;
					end else if (size_q[lv_q[LV_W-1:0]] != '0) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hstep_q == 4'd8) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == 5'd31) begin
						state_q <= S_KRD;
					end
				end
				S_KRD: begin
					state_q <= S_KCHK;
				end
				S_KCHK: begin
					if (wi_ok && key_rd[bitpos]) begin
						state_q <= S_RANK;
					end else begin
						state_q <= S_LVL;
					end
				end
				S_RANK: begin
					state_q <= (wi[2:0] == 3'd0) ? S_FIN : S_POP;
				end
				S_POP: begin
					if (jc_q + 3'd1 == wi[2:0]) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MISS: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				scalar_q <= cmd.scalar;
				lv_q     <= '0;
			end
			S_LVL: begin
				lsize_q <= size_q[lv_q[LV_W-1:0]];
				hstep_q <= '0;
				if (({1'b0, lv_q} < n_lv) && (size_q[lv_q[LV_W-1:0]] == '0)) begin
					lv_q <= lv_q + 1'b1;
				end
			end
			S_HASH: begin
				hstep_q <= hstep_q + 4'd1;
				dcnt_q  <= '0;
				rem_q   <= '0;
				case (hstep_q)
					4'd0, 4'd1, 4'd3, 4'd4: t_q <= prod;
					default:                h_q <= prod;
				endcase
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 5'd1;
				h_q    <= h_q << 1;
				rem_q  <= trial[16] ? shifted[15:0] : trial[15:0];
			end
			S_KCHK: begin
				word_q  <= key_rd;
				rk_ok_q <= (32'(rk) < 32'(RANKS_PER_LEVEL));
				if (!(wi_ok && key_rd[bitpos])) begin
					lv_q <= lv_q + 1'b1;
				end
			end
			S_RANK: begin
				acc_q <= rk_ok_q ? rank_rd : 16'd0;
				jc_q  <= '0;
			end
			S_POP: begin
				acc_q <= acc_q + 16'(pop64(key_rd));
				jc_q  <= jc_q + 3'd1;
			end
			S_FIN: begin
				result.result_index <= acc_q + 16'(pop64(word_q & below_mask));
				result.found        <= 1'b1;
			end
			S_MISS: begin
				result.result_index <= '0;
				result.found        <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule

// ===== src/mphl_checker.sv =====
// ----------------------------------------------------------------------------
// mphl_checker
// port-level checks on the mph lookup, bound to the top level
// ----------------------------------------------------------------------------
module mphl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input mphl_pkg::cmd_t cmd,
	input logic           done,
	input mphl_pkg::res_t result
);
	import mphl_pkg::*;

	// a result only closes a lookup in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy)) else $error("done without a lookup");

	// a lookup word raises busy
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_LOOKUP) |=> busy) else $error("lookup lost");

	// writes complete at once
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op != OP_LOOKUP) |=> (!busy && !done))
		else $error("write gave busy or result");

	// a miss reports index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.result_index == 16'd0))
		else $error("miss with nonzero index");

endmodule

bind minimal_perfect_hash_lookup_top mphl_checker u_mphl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the multi-level perfect hash lookup against a cycle-free predictor
// ----------------------------------------------------------------------------
// Table writes and lookups go in through the start/busy command port. Every
// accepted write updates a local copy of the key, rank and size tables, and
// every lookup pushes the index it should return. Before a lookup is sent the
// predictor walks the search and writes any key word or rank entry that the
// search would touch but that has never been written, so the block is never
// asked to read an empty entry. Results are matched in order as done pulses.
// ----------------------------------------------------------------------------
module testbench;
	import mphl_pkg::*;

	localparam int LEVELS      = 8;
	localparam int KEY_WORDS   = 1024;
	localparam int RANK_WORDS  = 128;
	localparam int CYCLE_LIMIT = 3000000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	cmd_t   cmd = '0;
	logic   done;
	res_t   result;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic [3:0] cfg_data = '0;

	// local copy of the block's tables
	logic [63:0] key_mem [LEVELS][KEY_WORDS];
	bit          key_set [LEVELS][KEY_WORDS];
	logic [15:0] rank_mem [LEVELS][RANK_WORDS];
	bit          rank_set [LEVELS][RANK_WORDS];
	logic [15:0] size_mem [LEVELS];
	logic [3:0]  levels_searched;

	res_t  pending_index [$];
	int    fail_count = 0;
	int    cycle_count = 0;
	bit    no_gaps = 1'b0;

	minimal_perfect_hash_lookup_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// overall time limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result checker: each done pulse is matched against the oldest expected index
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_index.size() == 0) begin
				$error("result with nothing expected: index %0h found %0b",
					result.result_index, result.found);
				fail_count++;
			end else begin
				want = pending_index.pop_front();
				if (result.result_index !== want.result_index) begin
					$error("result_index expected %0h actual %0h",
						want.result_index, result.result_index);
					fail_count++;
				end
				if (result.found !== want.found) begin
					$error("found expected %0b actual %0b", want.found, result.found);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] scramble_block(input logic [31:0] k);
		k = k * MM_C1;
		k = rot_left(k, 15);
		return k * MM_C2;
	endfunction

	// murmur3 over the scalar and the level size, seeded with the level number
	function automatic logic [31:0] level_hash(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] seed);
		logic [31:0] h;
		h = seed ^ scramble_block(a);
		h = rot_left(h, 13) * 32'd5 + MM_ADD;
		h = h ^ scramble_block(b);
		h = rot_left(h, 13) * 32'd5 + MM_ADD;
		h = h ^ MM_LEN;
		h = h ^ (h >> 16);
		h = h * MM_F1;
		h = h ^ (h >> 13);
		h = h * MM_F2;
		return h ^ (h >> 16);
	endfunction

	// walks the levels; returns 0 and names the first unwritten entry the search
	// would read (gap_op is OP_KEY or OP_RANK), else 1 with the expected result
	function automatic bit search_levels(input logic [20:0] scalar, output res_t r,
		output logic [1:0] gap_op, output int gap_lv, output int gap_addr);
		int n;
		logic [31:0] idx;
		int wi;
		int bit_pos;
		logic [15:0] rank;
		logic [63:0] w;
		r = '0;
		gap_op = OP_LOOKUP;
		gap_lv = 0;
		gap_addr = 0;
		n = (levels_searched > LEVELS) ? LEVELS : levels_searched;
		for (int lv = 0; lv < n; lv++) begin
			if (size_mem[lv] == 16'd0)
				continue;
			idx = level_hash({11'd0, scalar}, {16'd0, size_mem[lv]}, lv) % size_mem[lv];
			wi = idx >> 6;
			bit_pos = idx & 63;
			if (!key_set[lv][wi]) begin
				gap_op = OP_KEY; gap_lv = lv; gap_addr = wi;
				return 1'b0;
			end
			w = key_mem[lv][wi];
			if (w[bit_pos] == 1'b0)
				continue;
			if (!rank_set[lv][idx >> 9]) begin
				gap_op = OP_RANK; gap_lv = lv; gap_addr = idx >> 9;
				return 1'b0;
			end
			rank = rank_mem[lv][idx >> 9];
			for (int j = wi & ~7; j != wi; j++) begin
				if (!key_set[lv][j]) begin
					gap_op = OP_KEY; gap_lv = lv; gap_addr = j;
					return 1'b0;
				end
				rank = rank + 16'($countones(key_mem[lv][j]));
			end
			rank = rank + 16'($countones(w & ((64'd1 << bit_pos) - 64'd1)));
			r.result_index = rank;
			r.found = 1'b1;
			return 1'b1;
		end
		return 1'b1;
	endfunction

	// drives one word at a falling edge, waits for it to be taken, then maybe idles
	task automatic send_word(input cmd_t c);
		res_t r;
		logic [1:0] g_op;
		int g_lv;
		int g_addr;
		start = 1'b1;
		cmd = c;
		while (busy) @(negedge clk);
		@(posedge clk);
		// word taken at this edge: mirror it in the local tables
		case (c.op)
			OP_LOOKUP: begin
				void'(search_levels(c.scalar, r, g_op, g_lv, g_addr));
				pending_index.push_back(r);
			end
			OP_KEY: begin
				key_mem[c.level][c.address] = c.data;
				key_set[c.level][c.address] = 1'b1;
			end
			OP_RANK: begin
				if (c.address < RANK_WORDS) begin
					rank_mem[c.level][c.address] = c.data[15:0];
					rank_set[c.level][c.address] = 1'b1;
				end
			end
			OP_SIZE: size_mem[c.level] = c.data[15:0];
			default: ;
		endcase
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 31) begin
			start = 1'b0;
			cmd = '0;
			@(negedge clk);
		end
	endtask

	task automatic write_table(input logic [1:0] op, input int lv, input int addr,
		input logic [63:0] data);
		cmd_t c;
		c = '0;
		c.op = op;
		c.level = 3'(lv);
		c.address = 10'(addr);
		c.data = data;
		c.scalar = 21'($urandom);
		send_word(c);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// fills whatever the search would read before sending the lookup itself
	task automatic lookup(input logic [20:0] scalar);
		res_t r;
		logic [1:0] g_op;
		int g_lv;
		int g_addr;
		cmd_t c;
		while (!search_levels(scalar, r, g_op, g_lv, g_addr))
			write_table(g_op, g_lv, g_addr, rand64());
		c = '0;
		c.op = OP_LOOKUP;
		c.scalar = scalar;
		c.level = 3'($urandom);
		c.address = 10'($urandom);
		c.data = rand64();
		send_word(c);
	endtask

	task automatic drain();
		start = 1'b0;
		cmd = '0;
		while (pending_index.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_level_count(input logic [3:0] value);
		drain();
		cfg_valid = 1'b1;
		cfg_data = value;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		levels_searched = value;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = '0;
	endtask

	// straight after reset nothing is searched, then all levels are empty
	task automatic test_empty_tables();
		lookup(21'd0);
		lookup(21'h1FFFFF);
		set_level_count(4'd8);
		lookup(21'd1114111);
		lookup(21'd65);
	endtask

	// field extremes, ignored rank writes, zero-size level skips, 16-bit wrap
	task automatic test_directed();
		set_level_count(4'd15);
		write_table(OP_SIZE, 0, 0, 64'hFFFF_FFFF_FFFF_0000);
		write_table(OP_SIZE, 1, 1023, 64'hFFFF);
		write_table(OP_SIZE, 2, 0, 64'd1);
		write_table(OP_KEY, 7, 1023, '1);
		write_table(OP_RANK, 3, 1023, 64'h1234);
		write_table(OP_RANK, 3, 128, 64'h5678);
		lookup(21'd0);
		lookup(21'h1FFFFF);
		// dense level with a rank near the top so the index wraps
		write_table(OP_SIZE, 0, 0, 64'd512);
		for (int i = 0; i < 8; i++)
			write_table(OP_KEY, 0, i, '1);
		write_table(OP_RANK, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
		lookup(21'd1114111);
		lookup(21'd7);
		lookup(21'd300);
		// all clear level 0, single-bit level 2
		for (int i = 0; i < 8; i++)
			write_table(OP_KEY, 0, i, '0);
		write_table(OP_KEY, 2, 0, 64'd1);
		write_table(OP_RANK, 2, 0, 64'd0);
		lookup(21'd42);
		set_level_count(4'd1);
		lookup(21'd42);
	endtask

	// random table contents and lookups over a series of level counts
	task automatic test_random();
		logic [3:0] counts [8] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
		int lv;
		for (int ph = 0; ph < 8; ph++) begin
			set_level_count(counts[ph]);
			no_gaps = (ph == 3);
			// mostly small sizes, now and then one at the top of the range
			for (int l = 0; l < LEVELS; l++) begin
				if ($urandom_range(9) == 0)
					write_table(OP_SIZE, l, $urandom, {$urandom, $urandom_range(65535, 30000)});
				else if ($urandom_range(7) == 0)
					write_table(OP_SIZE, l, $urandom, 64'd0);
				else
					write_table(OP_SIZE, l, $urandom,
						64'({$urandom, 16'($urandom_range(1, 1500))}));
			end
			for (int k = 0; k < 200; k++) begin
				lv = $urandom_range(LEVELS - 1);
				case ($urandom_range(9))
					0: write_table(OP_KEY, lv, $urandom_range(KEY_WORDS - 1), rand64());
					1: write_table(OP_RANK, lv, $urandom_range(1023), rand64());
					default: lookup(21'($urandom));
				endcase
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		levels_searched = '0;
		for (int l = 0; l < LEVELS; l++) begin
			size_mem[l] = '0;
			for (int i = 0; i < KEY_WORDS; i++) key_set[l][i] = 1'b0;
			for (int i = 0; i < RANK_WORDS; i++) rank_set[l][i] = 1'b0;
		end
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_tables();
		test_directed();
		test_random();
		drain();
		repeat (400) @(negedge clk);
		if (fail_count == 0 && pending_index.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
